>>> rtl/dhs_pkg.sv
// Package with the shared types, codes and constants of the double-hashing set table.
package dhs_pkg;

  localparam int DEF_TABLE_DEPTH   = 256;
  localparam int DEF_MAX_KEY_BYTES = 8;

  localparam int KEY_W    = 64;
  localparam int LEN_W    = 4;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 8;
  localparam int CNT_W    = 9;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [FUNC_W-1:0] FN_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd2;
  localparam logic [FUNC_W-1:0] FN_COUNT  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_EMPTY_KEY = 3'd6;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_USED  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_MULT_A = 2'd1;
  localparam logic [1:0] REG_MULT_B = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_EVAL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       multiset;
    logic [7:0] mult_a;
    logic [7:0] mult_b;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic hash;
    logic rd;
    logic eval;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic empty_key;
    logic hash_last;
    logic ev_done;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/dhs_regs.sv
// Configuration register file behind the APB-style port.
module dhs_regs
  import dhs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MODE:   cfg.multiset <= pwdata[0];
        REG_MULT_A: cfg.mult_a   <= pwdata[7:0];
        REG_MULT_B: cfg.mult_b   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:   prdata = {{(PDATA_W-1){1'b0}}, cfg.multiset};
      REG_MULT_A: prdata = {{(PDATA_W-8){1'b0}}, cfg.mult_a};
      REG_MULT_B: prdata = {{(PDATA_W-8){1'b0}}, cfg.mult_b};
      default:    prdata = '0;
    endcase
  end

endmodule

>>> rtl/dhs_ctrl.sv
// Controller state machine that sequences clearing, hashing and the probe walk.
module dhs_ctrl
  import dhs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (sts.clear_last) state_next = S_IDLE;
      S_IDLE:  if (req_valid) state_next = S_HASH;
      S_HASH: begin
        if (sts.empty_key) state_next = S_DONE;
        else if (sts.hash_last) state_next = S_READ;
      end
      S_READ:  state_next = S_EVAL;
      S_EVAL:  state_next = sts.ev_done ? S_DONE : S_READ;
      S_DONE:  if (sts.out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd          = '0;
    req_stall    = (state != S_IDLE);
    cmd.clear    = (state == S_CLEAR);
    cmd.load     = (state == S_IDLE) && req_valid;
    cmd.hash     = (state == S_HASH) && !sts.empty_key;
    cmd.rd       = (state == S_READ);
    cmd.eval     = (state == S_EVAL);
    cmd.load_out = (state == S_DONE) && sts.out_free;
  end

endmodule

>>> rtl/dhs_datapath.sv
// Datapath with the slot memories, hash units, probe logic and result register.
module dhs_datapath
  import dhs_pkg::*;
#(
  parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
  parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  cfg_t                cfg,
  input  logic [FUNC_W-1:0]   func,
  input  logic [KEY_W-1:0]    key,
  input  logic [LEN_W-1:0]    key_len,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [STATUS_W-1:0] status,
  output logic [POS_W-1:0]    position,
  output logic [CNT_W-1:0]    match_count,
  output logic [CNT_W-1:0]    element_count
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int KW    = 8 * MAX_KEY_BYTES;
  localparam int LCW   = $clog2(TABLE_DEPTH + 1);

  logic [1:0]       stat_mem [TABLE_DEPTH];
  logic [KW-1:0]    key_mem  [TABLE_DEPTH];
  logic [LEN_W-1:0] len_mem  [TABLE_DEPTH];

  logic [IDX_W-1:0]    clr_addr;
  logic [FUNC_W-1:0]   op_func;
  logic [KW-1:0]       op_key;
  logic [KW-1:0]       hkey;
  logic [LEN_W-1:0]    op_len;
  logic [LEN_W-1:0]    rem;
  logic [IDX_W-1:0]    hash_a, hash_b;
  logic [IDX_W-1:0]    start_idx, step_val, cur;
  logic [1:0]          stat_q;
  logic [KW-1:0]       key_q;
  logic [LEN_W-1:0]    len_q;
  logic [LCW-1:0]      match_cnt;
  logic [LCW-1:0]      live_cnt;
  logic [STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]    res_pos;

  logic [LEN_W-1:0]    len_c;
  logic [KW-1:0]       key_m;
  logic [IDX_W+7:0]    sb, prod_a, prod_b;
  logic [IDX_W-1:0]    ha_next, hb_next;
  logic [IDX_W-1:0]    nxt;
  logic                wrap, match;
  logic                ev_done, do_ins, do_del, inc;
  logic [STATUS_W-1:0] st_n;
  logic [IDX_W-1:0]    pos_n;
  logic [31:0]         pos_ext, mc_ext, lc_ext;

  assign len_c = (key_len > LEN_W'(MAX_KEY_BYTES)) ? LEN_W'(MAX_KEY_BYTES) : key_len;

  always_comb begin
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      key_m[i*8 +: 8] = (LEN_W'(i) < len_c) ? key[i*8 +: 8] : 8'h00;
    end
  end

  assign sb      = {{IDX_W{hkey[7]}}, hkey[7:0]};
  assign prod_a  = {8'b0, hash_a} * {{IDX_W{1'b0}}, cfg.mult_a};
  assign prod_b  = {8'b0, hash_b} * {{IDX_W{1'b0}}, cfg.mult_b};
  assign ha_next = prod_a[IDX_W-1:0] + sb[IDX_W-1:0];
  assign hb_next = prod_b[IDX_W-1:0] + sb[IDX_W-1:0];

  assign nxt   = cur + step_val;
  assign wrap  = (nxt == start_idx);
  assign match = (stat_q == SLOT_USED) && (len_q == op_len) && (key_q == op_key);

  always_comb begin
    ev_done = 1'b0;
    do_ins  = 1'b0;
    do_del  = 1'b0;
    inc     = 1'b0;
    st_n    = res_status;
    pos_n   = res_pos;
    case (op_func)
      FN_ADD: begin
        if (stat_q != SLOT_USED) begin
          ev_done = 1'b1;
          do_ins  = 1'b1;
          st_n    = ST_INSERTED;
          pos_n   = cur;
        end else if (!cfg.multiset && match) begin
          ev_done = 1'b1;
          st_n    = ST_DUPLICATE;
          pos_n   = cur;
        end else if (wrap) begin
          ev_done = 1'b1;
          st_n    = ST_FULL;
          pos_n   = '0;
        end
      end
      FN_DELETE, FN_SEARCH: begin
        if (stat_q == SLOT_EMPTY) begin
          ev_done = 1'b1;
          st_n    = ST_NOT_FOUND;
          pos_n   = '0;
        end else if (match) begin
          ev_done = 1'b1;
          pos_n   = cur;
          if (op_func == FN_DELETE) begin
            do_del = 1'b1;
            st_n   = ST_DELETED;
          end else begin
            st_n = ST_FOUND;
          end
        end else if (wrap) begin
          ev_done = 1'b1;
          st_n    = ST_NOT_FOUND;
          pos_n   = '0;
        end
      end
      default: begin
        st_n  = ST_FOUND;
        pos_n = '0;
        if (stat_q == SLOT_EMPTY) begin
          ev_done = 1'b1;
        end else begin
          inc     = match;
          ev_done = wrap;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      stat_mem[clr_addr] <= SLOT_EMPTY;
    end else if (cmd.eval && do_ins) begin
      stat_mem[cur] <= SLOT_USED;
    end else if (cmd.eval && do_del) begin
      stat_mem[cur] <= SLOT_TOMB;
    end
    if (cmd.eval && do_ins) begin
      key_mem[cur] <= op_key;
      len_mem[cur] <= op_len;
    end
    if (cmd.rd) begin
      stat_q <= stat_mem[cur];
      key_q  <= key_mem[cur];
      len_q  <= len_mem[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      live_cnt <= '0;
    end else begin
      if (cmd.clear) clr_addr <= clr_addr + 1'b1;
      if (cmd.eval && do_ins) live_cnt <= live_cnt + 1'b1;
      else if (cmd.eval && do_del) live_cnt <= live_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_func    <= func;
      op_key     <= key_m;
      hkey       <= key_m;
      op_len     <= len_c;
      rem        <= len_c;
      hash_a     <= '0;
      hash_b     <= '0;
      match_cnt  <= '0;
      res_status <= (len_c == '0) ? ST_EMPTY_KEY : ST_NOT_FOUND;
      res_pos    <= '0;
    end
    if (cmd.hash) begin
      hash_a <= ha_next;
      hash_b <= hb_next;
      hkey   <= hkey >> 8;
      rem    <= rem - 1'b1;
      if (sts.hash_last) begin
        start_idx <= ha_next;
        cur       <= ha_next;
        step_val  <= {hb_next[IDX_W-1:1], 1'b1};
      end
    end
    if (cmd.eval) begin
      cur        <= nxt;
      res_status <= st_n;
      res_pos    <= pos_n;
      match_cnt  <= match_cnt + LCW'(inc);
    end
  end

  assign pos_ext = 32'(res_pos);
  assign mc_ext  = 32'(match_cnt);
  assign lc_ext  = 32'(live_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status        <= res_status;
      position      <= pos_ext[POS_W-1:0];
      match_count   <= mc_ext[CNT_W-1:0];
      element_count <= lc_ext[CNT_W-1:0];
    end
  end

  always_comb begin
    sts.clear_last = (clr_addr == '1);
    sts.empty_key  = (op_len == '0);
    sts.hash_last  = (rem == LEN_W'(1));
    sts.ev_done    = ev_done;
    sts.out_free   = !rsp_valid || !rsp_stall;
  end

endmodule

>>> rtl/double_hash_set_table.sv
// Top level of the open-addressed hash set table with double hashing.
//
// A request transfer on req_valid/req_stall carries func, key and key_len.
// Each request answers with one result transfer on rsp_valid/rsp_stall
// carrying status, position, match_count and element_count.
// Configuration registers (multiset mode, hash multipliers A and B) sit on
// the APB-style port at byte addresses 0, 4 and 8; pready is always high.
// One request is in work at a time. It is accepted in S_IDLE; the two
// hash units then take in the key one byte at a time (S_HASH); each slot
// probed takes a registered read of the slot memories (S_READ), then the
// compare (S_EVAL); and S_DONE loads the result register once the output
// is free. The slot memory read port sets the probe rate.
// After reset the block sweeps the slot status memory to empty, one slot a
// cycle, with req_stall high; configuration writes are taken meanwhile.
// While the receiver stalls, the result holds, and the next request can be
// accepted and worked until its result is ready.
module double_hash_set_table
  import dhs_pkg::*;
#(
  parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
  parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [FUNC_W-1:0]   func,
  input  logic [KEY_W-1:0]    key,
  input  logic [LEN_W-1:0]    key_len,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [STATUS_W-1:0] status,
  output logic [POS_W-1:0]    position,
  output logic [CNT_W-1:0]    match_count,
  output logic [CNT_W-1:0]    element_count
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  dhs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dhs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dhs_datapath #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg           (cfg),
    .func          (func),
    .key           (key),
    .key_len       (key_len),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .position      (position),
    .match_count   (match_count),
    .element_count (element_count)
  );

endmodule

>>> rtl/dhs_checker.sv
// Port-level assertion checker for the hash set table, with its bind statement.
module dhs_checker
  import dhs_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input logic [STATUS_W-1:0] status,
  input logic [POS_W-1:0]    position,
  input logic [CNT_W-1:0]    match_count
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("Result valid after reset.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("Request accepted while another is in work.");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(status) && $stable(position)))
    else $error("Stalled result changed.");

  a_count_only: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && match_count != '0) |-> (status == ST_FOUND))
    else $error("Match count on a result that is not a count.");

  a_no_pos: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (status == ST_NOT_FOUND || status == ST_FULL ||
                   status == ST_EMPTY_KEY)) |-> (position == '0))
    else $error("Position set on a result without a slot.");

endmodule

bind double_hash_set_table dhs_checker u_dhs_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req_valid),
  .req_stall   (req_stall),
  .rsp_valid   (rsp_valid),
  .rsp_stall   (rsp_stall),
  .status      (status),
  .position    (position),
  .match_count (match_count)
);
